// ===== rtl/binary_min_heap_priority_queue_macros.svh =====
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle check: cons must hold whenever ante holds.
`define BMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define BMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmh_pkg.sv =====
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 63;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child index can run past the store, so keep two spare bits
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int STATUS_W = 2;

    localparam int IN_FIELDS_W  = 1 + KEY_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = KEY_BITS + STATUS_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UP_CMP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUT      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EX_LOAD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DN_CMP   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd6;

    typedef struct packed {
        logic             load;   // input word taken this cycle
        logic [CMD_W-1:0] cmd;
    } ctrl_t;

    typedef struct packed {
        logic is_extract;
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic up_go;     // new key below its parent
        logic up_top;    // parent is the root
        logic dn_go;     // a child is strictly smaller
        logic dn_leaf;   // chosen child has no children
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/bmh_ram.sv =====
module bmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/bmh_ctrl.sv =====
module bmh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bmh_pkg::stat_t stat,
    output bmh_pkg::ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_UP_CMP   = 3'd2;
    localparam logic [2:0] S_PUT      = 3'd3;
    localparam logic [2:0] S_EX_LOAD  = 3'd4;
    localparam logic [2:0] S_DN_CMP   = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // no word is taken while reset is held
    assign s_tready = aresetn && (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctrl.load  = 1'b0;
        ctrl.cmd   = bmh_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                ctrl.cmd = bmh_pkg::CMD_DISPATCH;
                if (stat.is_extract) begin
                    state_next = stat.cnt_zero ? S_FINISH : S_EX_LOAD;
                end else if (stat.full) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = stat.cnt_zero ? S_PUT : S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ctrl.cmd = bmh_pkg::CMD_UP_CMP;
                if (!stat.up_go) begin
                    state_next = S_FINISH;
                end else if (stat.up_top) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                ctrl.cmd   = bmh_pkg::CMD_PUT;
                state_next = S_FINISH;
            end
            S_EX_LOAD: begin
                // count is already decremented here
                ctrl.cmd = bmh_pkg::CMD_EX_LOAD;
                if (stat.cnt_zero) begin
                    state_next = S_FINISH;
                end else if (stat.cnt_one) begin
                    state_next = S_PUT;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                ctrl.cmd = bmh_pkg::CMD_DN_CMP;
                if (!stat.dn_go) begin
                    state_next = S_FINISH;
                end else if (stat.dn_leaf) begin
                    state_next = S_PUT;
                end
            end
            S_FINISH: begin
                ctrl.cmd = bmh_pkg::CMD_FINISH;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bmh_datapath.sv =====
module bmh_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [bmh_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bmh_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  bmh_pkg::ctrl_t                   ctrl,
    output bmh_pkg::stat_t                   stat
);

    localparam int KB = bmh_pkg::KEY_BITS;
    localparam int AW = bmh_pkg::ADDR_W;
    localparam int CW = bmh_pkg::CNT_W;
    localparam int HW = bmh_pkg::CHILD_W;

    logic                            op_reg, op_next;
    logic [KB-1:0]                   key_reg, key_next;
    logic [AW-1:0]                   hole_reg, hole_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [KB-1:0]                   result_reg, result_next;
    logic [bmh_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [bmh_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KB-1:0] wr_data;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [KB-1:0] rd_data_a, rd_data_b;

    bmh_ram #(
        .WIDTH (KB),
        .DEPTH (bmh_pkg::CAPACITY)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // address arithmetic
    logic [AW-1:0] cnt_par, hole_par, hole_pp;
    logic [HW-1:0] lc_w, rc_w, n_w, nlc_w, nrc_w;
    logic          l_less, r_less;
    logic [KB-1:0] cand, best_val;
    logic [AW-1:0] best;
    logic          out_free;

    always_comb begin
        cnt_par  = AW'((cnt_reg - CW'(1)) >> 1);
        hole_par = (hole_reg - AW'(1)) >> 1;
        hole_pp  = (hole_par - AW'(1)) >> 1;

        n_w    = HW'(cnt_reg);
        lc_w   = (HW'(hole_reg) << 1) | HW'(1);
        rc_w   = lc_w + HW'(1);
        // strict compares; left wins a tie between two smaller children
        l_less = (lc_w < n_w) && (rd_data_a < key_reg);
        cand   = l_less ? rd_data_a : key_reg;
        r_less = (rc_w < n_w) && (rd_data_b < cand);
        best   = r_less ? AW'(rc_w) : (l_less ? AW'(lc_w) : hole_reg);
        best_val = r_less ? rd_data_b : rd_data_a;
        nlc_w  = (HW'(best) << 1) | HW'(1);
        nrc_w  = nlc_w + HW'(1);

        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        stat.is_extract = op_reg;
        stat.full       = (cnt_reg == CW'(bmh_pkg::CAPACITY));
        stat.cnt_zero   = (cnt_reg == '0);
        stat.cnt_one    = (cnt_reg == CW'(1));
        stat.up_go      = (key_reg < rd_data_a);
        stat.up_top     = (hole_par == '0);
        stat.dn_go      = l_less || r_less;
        stat.dn_leaf    = (nlc_w >= n_w);
        stat.out_free   = out_free;
    end

    always_comb begin
        op_next       = op_reg;
        key_next      = key_reg;
        hole_next     = hole_reg;
        cnt_next      = cnt_reg;
        result_next   = result_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = hole_reg;
        wr_data       = key_reg;
        rd_addr_a     = '0;
        rd_addr_b     = '0;

        if (ctrl.load) begin
            op_next  = s_tdata[0];
            key_next = s_tdata[KB:1];
        end

        case (ctrl.cmd)
            bmh_pkg::CMD_DISPATCH: begin
                status_next = bmh_pkg::ST_OK;
                result_next = '0;
                if (op_reg) begin
                    if (cnt_reg == '0) begin
                        status_next = bmh_pkg::ST_EMPTY;
                    end else begin
                        cnt_next  = cnt_reg - CW'(1);
                        rd_addr_a = '0;
                        rd_addr_b = AW'(cnt_reg - CW'(1));
                    end
                end else if (cnt_reg == CW'(bmh_pkg::CAPACITY)) begin
                    status_next = bmh_pkg::ST_FULL;
                end else begin
                    hole_next = cnt_reg[AW-1:0];
                    cnt_next  = cnt_reg + CW'(1);
                    rd_addr_a = cnt_par;
                end
            end
            bmh_pkg::CMD_UP_CMP: begin
                wr_en = 1'b1;
                if (key_reg < rd_data_a) begin
                    // parent drops into the hole, hole climbs
                    wr_data   = rd_data_a;
                    hole_next = hole_par;
                    rd_addr_a = hole_pp;
                end
            end
            bmh_pkg::CMD_PUT: begin
                wr_en = 1'b1;
            end
            bmh_pkg::CMD_EX_LOAD: begin
                result_next = rd_data_a;
                key_next    = rd_data_b;
                hole_next   = '0;
                rd_addr_a   = AW'(1);
                rd_addr_b   = AW'(2);
            end
            bmh_pkg::CMD_DN_CMP: begin
                wr_en = 1'b1;
                if (l_less || r_less) begin
                    wr_data   = best_val;
                    hole_next = best;
                    rd_addr_a = AW'(nlc_w);
                    rd_addr_b = AW'(nrc_w);
                end
            end
            bmh_pkg::CMD_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = bmh_pkg::OUT_TDATA_W'({cnt_reg, status_reg, result_reg});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        key_reg     <= key_next;
        hole_reg    <= hole_next;
        result_reg  <= result_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/binary_min_heap_priority_queue.sv =====
// Throughput: one word in flight; the sift moves one heap level per cycle through the
//   dual-read store, and a finished word waits in FINISH until the output register is free
//   (m_tready back-pressure).
// Reset: aresetn low clears the controller, entry count and output valid synchronously;
//   the key store is not cleared, only entries below the count are ever used.
`include "binary_min_heap_priority_queue_macros.svh"

module binary_min_heap_priority_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bmh_pkg::IN_TDATA_W-1:0]   s_tdata,  // op, key
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bmh_pkg::OUT_TDATA_W-1:0]  m_tdata   // result_key, status, count, zero pad
);

    bmh_pkg::ctrl_t ctrl;
    bmh_pkg::stat_t stat;

    bmh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bmh_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    logic [bmh_pkg::KEY_BITS-1:0] out_key;
    logic [bmh_pkg::STATUS_W-1:0] out_status;
    logic [bmh_pkg::CNT_W-1:0]    out_count;

    assign out_key    = m_tdata[bmh_pkg::KEY_BITS-1:0];
    assign out_status = m_tdata[bmh_pkg::KEY_BITS+bmh_pkg::STATUS_W-1:bmh_pkg::KEY_BITS];
    assign out_count  = m_tdata[bmh_pkg::OUT_FIELDS_W-1:bmh_pkg::KEY_BITS+bmh_pkg::STATUS_W];

    `BMH_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "word taken while busy")
    `BMH_ASSERT_NOW(a_count_range, m_tvalid, out_count <= bmh_pkg::CNT_W'(bmh_pkg::CAPACITY), "count above capacity")
    `BMH_ASSERT_NOW(a_empty_result, m_tvalid && (out_status == bmh_pkg::ST_EMPTY), (out_key == '0) && (out_count == '0), "bad empty result")
    `BMH_ASSERT_NOW(a_full_result, m_tvalid && (out_status == bmh_pkg::ST_FULL), (out_key == '0) && (out_count == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY)), "bad full result")

endmodule

// ===== bench/binary_min_heap_priority_queue_test.sv =====
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_test;

    localparam int KEY_BITS    = bmh_pkg::KEY_BITS;
    localparam int CAPACITY    = bmh_pkg::CAPACITY;
    localparam int STATUS_W    = bmh_pkg::STATUS_W;
    localparam int CNT_W       = bmh_pkg::CNT_W;
    localparam int IN_TDATA_W  = bmh_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = bmh_pkg::OUT_TDATA_W;

    localparam bit OP_INSERT  = 1'b0;
    localparam bit OP_EXTRACT = 1'b1;

    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int RECEIVER_HOLD = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_ROWS = 24;

    typedef struct {
        logic [KEY_BITS-1:0] key;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } heap_result_t;

    typedef struct {
        bit                  op;
        logic [KEY_BITS-1:0] key;
        bit                  typed;
        logic [KEY_BITS-1:0] exp_key;
        logic [STATUS_W-1:0] exp_status;
        logic [CNT_W-1:0]    exp_count;
    } directed_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    binary_min_heap_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // software copy of the heap
    logic [KEY_BITS-1:0] heap_keys [CAPACITY];
    int                  heap_count;

    heap_result_t  pending_results [$];
    directed_row_t directed_rows [DIRECTED_ROWS];
    int            mismatch_count;
    int unsigned   cycle_count = 0;
    int            burst_left;
    bit            hold_req;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic heap_result_t predict_heap_op(bit op, logic [KEY_BITS-1:0] key);
        heap_result_t        res;
        logic [KEY_BITS-1:0] tmp;
        int                  pos;
        int                  parent;
        int                  lc;
        int                  rc;
        int                  best;
        res.key    = '0;
        res.status = bmh_pkg::ST_OK;
        if (op == OP_INSERT) begin
            if (heap_count >= CAPACITY) begin
                res.status = bmh_pkg::ST_FULL;
            end else begin
                heap_keys[heap_count] = key;
                pos = heap_count;
                heap_count++;
                // climb only past a strictly larger parent
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[pos] < heap_keys[parent]) begin
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[parent];
                        heap_keys[parent] = tmp;
                        pos = parent;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (heap_count == 0) begin
                res.status = bmh_pkg::ST_EMPTY;
            end else begin
                res.key = heap_keys[0];
                heap_count--;
                heap_keys[0] = heap_keys[heap_count];
                pos = 0;
                // left child wins a tie between two smaller children
                while (pos < heap_count) begin
                    lc = 2 * pos + 1;
                    rc = lc + 1;
                    best = pos;
                    if (lc < heap_count && heap_keys[lc] < heap_keys[best]) best = lc;
                    if (rc < heap_count && heap_keys[rc] < heap_keys[best]) best = rc;
                    if (best == pos) break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        res.count = heap_count[CNT_W-1:0];
        return res;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return raw[KEY_BITS-1:0];
            1: return KEY_BITS'($urandom_range(0, 15));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return KEY_MAX;
                    2: return KEY_MAX - KEY_BITS'(1);
                    default: return KEY_BITS'(1);
                endcase
            end
            default: return {3'b111, raw[KEY_BITS-4:0]};
        endcase
    endfunction

    // one word on the input channel, bursts with random gaps in between
    task automatic offer_word(bit op, logic [KEY_BITS-1:0] key, bit typed,
                              heap_result_t typed_res);
        int           gap;
        heap_result_t predicted;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, op};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_heap_op(op, key);
        pending_results.push_back(typed ? typed_res : predicted);
        burst_left--;
    endtask

    task automatic offer_random(bit op);
        heap_result_t none;
        none = '{default: '0};
        offer_word(op, pick_key(), 1'b0, none);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_word(logic [OUT_TDATA_W-1:0] word);
        heap_result_t got;
        heap_result_t want;
        got.key    = word[KEY_BITS-1:0];
        got.status = word[KEY_BITS +: STATUS_W];
        got.count  = word[KEY_BITS + STATUS_W +: CNT_W];
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected word key=%h status=%0d count=%0d",
                     $realtime, got.key, got.status, got.count);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.key !== want.key) begin
                $display("%0t: key mismatch expected %h actual %h",
                         $realtime, want.key, got.key);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $realtime, want.status, got.status);
                mismatch_count++;
            end
            if (got.count !== want.count) begin
                $display("%0t: count mismatch expected %0d actual %0d",
                         $realtime, want.count, got.count);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_word(m_tdata);
    end

    // receiver: stall pattern changes between stretches of random length, plus one long hold
    initial begin
        int mode;
        int len;
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(20, 200);
            repeat (len) begin
                @(negedge aclk);
                if (hold_req && !hold_done) begin
                    m_tready <= 1'b0;
                    repeat (RECEIVER_HOLD) @(negedge aclk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        heap_result_t row_res;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        burst_left     = 0;
        hold_req       = 1'b0;
        heap_count     = 0;

        directed_rows = '{
            '{OP_EXTRACT, '0,      1'b1, '0,      bmh_pkg::ST_EMPTY, 11'd0},
            '{OP_EXTRACT, KEY_MAX, 1'b1, '0,      bmh_pkg::ST_EMPTY, 11'd0},
            '{OP_INSERT,  KEY_MAX, 1'b1, '0,      bmh_pkg::ST_OK,    11'd1},
            '{OP_INSERT,  '0,      1'b1, '0,      bmh_pkg::ST_OK,    11'd2},
            '{OP_EXTRACT, '0,      1'b1, '0,      bmh_pkg::ST_OK,    11'd1},
            '{OP_EXTRACT, '0,      1'b1, KEY_MAX, bmh_pkg::ST_OK,    11'd0},
            '{OP_EXTRACT, '0,      1'b1, '0,      bmh_pkg::ST_EMPTY, 11'd0},
            // equal smaller children under the moved-down entry
            '{OP_INSERT,  63'd1,   1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_INSERT,  63'd5,   1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_INSERT,  63'd5,   1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_INSERT,  63'd9,   1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, KEY_MAX, 1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, '0,      1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, '0,      1'b0, '0, bmh_pkg::ST_OK, '0},
            // equal keys sifting up
            '{OP_INSERT,  63'd7,   1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_INSERT,  63'd7,   1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_INSERT,  63'd3,   1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_INSERT,  63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_INSERT,  63'h5555_5555_5555_5555, 1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, '0,      1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, '0,      1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, '0,      1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, '0,      1'b0, '0, bmh_pkg::ST_OK, '0},
            '{OP_EXTRACT, '0,      1'b0, '0, bmh_pkg::ST_OK, '0}
        };

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row_res.key    = directed_rows[i].exp_key;
            row_res.status = directed_rows[i].exp_status;
            row_res.count  = directed_rows[i].exp_count;
            offer_word(directed_rows[i].op, directed_rows[i].key,
                       directed_rows[i].typed, row_res);
        end

        // mixed traffic around a small heap, hitting empty now and then
        for (int n = 0; n < 600; n++) begin
            if (n == 300) hold_req = 1'b1;
            offer_random(($urandom_range(0, 99) < 45) ? OP_EXTRACT : OP_INSERT);
        end
        wait_for_results();

        // fill to capacity, then bounce off the top
        while (heap_count < CAPACITY) offer_random(OP_INSERT);
        repeat (3) offer_random(OP_INSERT);
        offer_random(OP_EXTRACT);
        offer_random(OP_INSERT);
        offer_random(OP_INSERT);

        // deep sifts near a full heap
        for (int n = 0; n < 250; n++)
            offer_random(($urandom_range(0, 99) < 45) ? OP_EXTRACT : OP_INSERT);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
